// ===== rtl/rffd_pkg.sv =====
// rffd_pkg: constants, result type and MAC byte helper for the rx frame filter/deframer.
// No dependencies; imported by rffd_parse and rx_frame_filter_deframer.
package rffd_pkg;

   localparam int unsigned MAX_FRAME_BYTES_DEF = 65536;
   localparam int unsigned HDR_BYTES           = 24;
   localparam logic [15:0] ETHER_OK            = 16'hCAB2;
   localparam logic [47:0] UNSET_MAC           = 48'h00FC70FFFFFF;
   localparam logic [7:0]  BCAST_BYTE          = 8'hFF;
   localparam int unsigned CSR_IDX_W           = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_MAC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_MAC = 2'd1;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        frame_done;
      logic        accepted;
      logic        short_payload;
      logic [15:0] payload_length;
      logic [15:0] packet_number;
      logic [31:0] header_word;
      logic        first_piece;
      logic        last_piece;
      logic        buffer_half_full;
   } rsp_type;

   // byte idx of a MAC in wire order, first byte in bits 47..40
   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = mac[47:40];
         3'd1: b = mac[39:32];
         3'd2: b = mac[31:24];
         3'd3: b = mac[23:16];
         3'd4: b = mac[15:8];
         3'd5: b = mac[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/rffd_parse.sv =====
// rffd_parse: per-frame header parse state, filters and result word build.
// Depends on rffd_pkg. State updates only on reset or when the top level steps a word.
module rffd_parse #(
   parameter int unsigned MaxFrameBytes = rffd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   input  logic              end_of_frame,
   input  logic [47:0]       host_mac,
   input  logic [47:0]       device_mac,
   output logic              has_rsp,
   output rffd_pkg::rsp_type rsp
);
   import rffd_pkg::*;

   localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic            dst_host_ff, dst_host_in;
   logic            dst_bcast_ff, dst_bcast_in;
   logic            dst_unset_ff, dst_unset_in;
   logic            src_dev_ff, src_dev_in;
   logic [15:0]     etype_ff, etype_in;
   logic [31:0]     hdr_ff, hdr_in;
   logic [15:0]     size_ff, size_in;
   logic [15:0]     pkt_ff, pkt_in;
   logic [2:0]      info_ff, info_in;
   logic [15:0]     sent_ff, sent_in;

   logic            in_range;
   logic            pass_now;
   logic            pass_next;
   logic            full;
   logic            acc;
   logic [2:0]      src_idx;

   assign in_range  = pos_ff < PosW'(MaxFrameBytes);
   assign src_idx   = 3'(pos_ff - PosW'(6));
   assign pass_now  = (etype_ff == ETHER_OK) && (dst_host_ff || dst_bcast_ff || dst_unset_ff)
                      && src_dev_ff;

   always_comb begin
      pos_in       = pos_ff;
      dst_host_in  = dst_host_ff;
      dst_bcast_in = dst_bcast_ff;
      dst_unset_in = dst_unset_ff;
      src_dev_in   = src_dev_ff;
      etype_in     = etype_ff;
      hdr_in       = hdr_ff;
      size_in      = size_ff;
      pkt_in       = pkt_ff;
      info_in      = info_ff;
      sent_in      = sent_ff;
      rsp          = '0;
      if (in_range) begin
         pos_in = pos_ff + PosW'(1);
         if (pos_ff < PosW'(6)) begin
            if (rx_byte != mac_byte(host_mac, pos_ff[2:0]))  dst_host_in  = 1'b0;
            if (rx_byte != BCAST_BYTE)                       dst_bcast_in = 1'b0;
            if (rx_byte != mac_byte(UNSET_MAC, pos_ff[2:0])) dst_unset_in = 1'b0;
         end else if (pos_ff < PosW'(12)) begin
            if (rx_byte != mac_byte(device_mac, src_idx)) src_dev_in = 1'b0;
         end else if (pos_ff < PosW'(14)) begin
            etype_in = {etype_ff[7:0], rx_byte};
         end else if (pos_ff < PosW'(18)) begin
            hdr_in = {hdr_ff[23:0], rx_byte};
         end else if (pos_ff == PosW'(18)) begin
            size_in = {size_ff[15:8], rx_byte};
         end else if (pos_ff == PosW'(19)) begin
            size_in = {rx_byte, size_ff[7:0]};
         end else if (pos_ff == PosW'(20)) begin
            pkt_in = {pkt_ff[15:8], rx_byte};
         end else if (pos_ff == PosW'(21)) begin
            pkt_in = {rx_byte, pkt_ff[7:0]};
         end else if (pos_ff == PosW'(22)) begin
            info_in = rx_byte[2:0];
         end else if (pos_ff >= PosW'(HDR_BYTES)) begin
            if (pass_now && (sent_ff < size_ff)) begin
               rsp.data_valid = 1'b1;
               rsp.data_byte  = rx_byte;
               sent_in        = sent_ff + 16'd1;
            end
         end
      end
      // frame reaches full header once byte 23 has been seen
      full      = pos_ff >= PosW'(HDR_BYTES - 1);
      pass_next = (etype_in == ETHER_OK) && (dst_host_in || dst_bcast_in || dst_unset_in)
                  && src_dev_in;
      acc       = full && pass_next;
      if (end_of_frame) begin
         rsp.frame_done    = 1'b1;
         rsp.accepted      = acc;
         rsp.short_payload = acc && (sent_in < size_in);
         if (full) begin
            rsp.payload_length   = size_in;
            rsp.packet_number    = pkt_in;
            rsp.header_word      = hdr_in;
            rsp.first_piece      = info_in[0];
            rsp.last_piece       = info_in[1];
            rsp.buffer_half_full = info_in[2];
         end
      end
      has_rsp = rsp.data_valid || end_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_frame)) begin
         pos_ff       <= '0;
         dst_host_ff  <= 1'b1;
         dst_bcast_ff <= 1'b1;
         dst_unset_ff <= 1'b1;
         src_dev_ff   <= 1'b1;
         etype_ff     <= '0;
         hdr_ff       <= '0;
         size_ff      <= '0;
         pkt_ff       <= '0;
         info_ff      <= '0;
         sent_ff      <= '0;
      end else if (step) begin
         pos_ff       <= pos_in;
         dst_host_ff  <= dst_host_in;
         dst_bcast_ff <= dst_bcast_in;
         dst_unset_ff <= dst_unset_in;
         src_dev_ff   <= src_dev_in;
         etype_ff     <= etype_in;
         hdr_ff       <= hdr_in;
         size_ff      <= size_in;
         pkt_ff       <= pkt_in;
         info_ff      <= info_in;
         sent_ff      <= sent_in;
      end
   end

   a_sent_bound: assert property (@(posedge clock) disable iff (reset)
      sent_ff <= size_ff || sent_ff == 16'd0)
      else $error("forwarded count exceeds declared size");

   a_pos_cap: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosW'(MaxFrameBytes))
      else $error("byte position past capture limit");

   a_data_needs_pass: assert property (@(posedge clock) disable iff (reset)
      step && rsp.data_valid |-> pass_now && pos_ff >= PosW'(HDR_BYTES))
      else $error("payload forwarded from unfiltered frame");

endmodule

// ===== rtl/rx_frame_filter_deframer.sv =====
// rx_frame_filter_deframer: top level; input word register, parse logic, result register.
// Depends on rffd_pkg and rffd_parse.
//
//  channel | ports                      | direction | handshake
//  req     | req_rx_byte, req_end_of_.. | in        | req_valid / req_stall
//  rsp     | rsp_data_byte .. rsp_buf.. | out       | rsp_valid / rsp_stall
//  csr     | csr_index, csr_wdata       | in        | csr_wr_en, no wait
//
// One word per clock while req_stall is low; results pass input then result register.
// A word that gives no result retires without touching the result register.
// Reset (synchronous) empties both registers and clears the frame state and MACs.
// rsp_stall holds the result register; req_stall rises only when the input
// register holds a word with a result and the result register cannot drain.
module rx_frame_filter_deframer #(
   parameter int unsigned MaxFrameBytes = rffd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   input  logic                               req_end_of_frame,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_data_byte,
   output logic                               rsp_data_valid,
   output logic                               rsp_frame_done,
   output logic                               rsp_accepted,
   output logic                               rsp_short_payload,
   output logic [15:0]                        rsp_payload_length,
   output logic [15:0]                        rsp_packet_number,
   output logic [31:0]                        rsp_header_word,
   output logic                               rsp_first_piece,
   output logic                               rsp_last_piece,
   output logic                               rsp_buffer_half_full,
   input  logic                               csr_wr_en,
   input  logic [rffd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [47:0]                        csr_wdata
);
   import rffd_pkg::*;

   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eof_ff;
   logic        out_vld_ff;
   rsp_type     out_ff;
   logic [47:0] host_mac_ff;
   logic [47:0] dev_mac_ff;

   logic        has_rsp;
   rsp_type     rsp_w;
   logic        out_free;
   logic        step;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && (!has_rsp || out_free);
   assign req_stall = in_vld_ff && !step;

   rffd_parse #(.MaxFrameBytes(MaxFrameBytes)) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .end_of_frame (in_eof_ff),
      .host_mac     (host_mac_ff),
      .device_mac   (dev_mac_ff),
      .has_rsp      (has_rsp),
      .rsp          (rsp_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         host_mac_ff <= '0;
         dev_mac_ff  <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_HOST_MAC)   host_mac_ff <= csr_wdata;
         if (csr_index == CSR_DEVICE_MAC) dev_mac_ff  <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
         in_eof_ff  <= req_end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= step && has_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && step && has_rsp) begin
         out_ff <= rsp_w;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_data_byte        = out_ff.data_byte;
   assign rsp_data_valid       = out_ff.data_valid;
   assign rsp_frame_done       = out_ff.frame_done;
   assign rsp_accepted         = out_ff.accepted;
   assign rsp_short_payload    = out_ff.short_payload;
   assign rsp_payload_length   = out_ff.payload_length;
   assign rsp_packet_number    = out_ff.packet_number;
   assign rsp_header_word      = out_ff.header_word;
   assign rsp_first_piece      = out_ff.first_piece;
   assign rsp_last_piece       = out_ff.last_piece;
   assign rsp_buffer_half_full = out_ff.buffer_half_full;

   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_ff.data_valid || out_ff.frame_done)
      else $error("empty result word");

   a_status_at_end: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && (out_ff.accepted || out_ff.short_payload) |-> out_ff.frame_done)
      else $error("status without frame end");

   a_short_needs_acc: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.short_payload |-> out_ff.accepted)
      else $error("short flag on rejected frame");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_stall |=> out_vld_ff && $stable(out_ff))
      else $error("held result changed");

endmodule
